// ===== rtl/core/sdcs_pkg.sv =====
// Shared constants, codes and helpers of the round-cone distance pipeline.
package sdcs_pkg;

  localparam int DIM      = 3;           // 2 drops the z axis
  localparam int CRD_W    = 32;          // Q16.16 coordinate
  localparam int RAD_W    = 31;          // Q16.16 radius
  localparam int IDX_W    = 3;           // register index
  localparam int FX_W     = CRD_W - 2;   // Q.13 difference
  localparam int RQ_W     = RAD_W - 3;   // Q.13 radius
  localparam int DR_W     = RQ_W + 1;    // signed radius difference
  localparam int SQ_W     = 2 * FX_W;    // sum of squares
  localparam int DOT_W    = SQ_W + 1;    // signed dot product

  localparam int RT_OUT_W = 32;
  localparam int RT_IN_W  = 2 * RT_OUT_W;
  localparam int RT_REM_W = RT_OUT_W + 2;
  localparam int RT_LAT   = RT_OUT_W;

  localparam int DV_N_W   = DOT_W;
  localparam int DV_D_W   = FX_W;
  localparam int DV_Q_W   = 33;
  localparam int DV_LAT   = DV_Q_W + 1;

  localparam int PIPE_LAT = 10 + 2 * RT_LAT + 3 * DV_LAT;

  localparam logic signed [CRD_W-1:0] DIST_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] DIST_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_START_RAD,
    REG_END_RAD
  } cfg_reg_t;

  // Exact Q16.16 difference, floored to Q.13.
  function automatic logic signed [FX_W-1:0] fdiff(logic signed [CRD_W-1:0] a,
                                                    logic signed [CRD_W-1:0] b);
    logic signed [CRD_W:0] d;
    d = $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
    return d[CRD_W:3];
  endfunction

  // Magnitude of a radius difference.
  function automatic logic [RQ_W-1:0] dr_mag(logic signed [DR_W-1:0] dr);
    logic signed [DR_W-1:0] n;
    n = -dr;
    return dr[DR_W-1] ? n[RQ_W-1:0] : dr[RQ_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sdcs_in_if.sv =====
// Query point channel.
interface sdcs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sdcs_pkg::CRD_W-1:0]      point_x;
  logic signed [sdcs_pkg::CRD_W-1:0]      point_y;
  logic signed [sdcs_pkg::CRD_W-1:0]      point_z;
  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// ===== rtl/core/sdcs_out_if.sv =====
// Distance result channel.
interface sdcs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sdcs_pkg::CRD_W-1:0]      distance;
  logic                                   valid_res;
  modport source (output valid, output distance, output valid_res, input ready);
  modport sink   (input valid, input distance, input valid_res, output ready);
endinterface

// ===== rtl/core/sdcs_cfg_if.sv =====
// Register write channel.
interface sdcs_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [sdcs_pkg::IDX_W-1:0]             index;
  logic [sdcs_pkg::CRD_W-1:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sdcs_root.sv =====
// Pipelined floor square root, one result bit per stage.
module sdcs_root (
  input  logic                             clk,
  input  logic                             en,
  input  logic [sdcs_pkg::RT_IN_W-1:0]     rad,
  output logic [sdcs_pkg::RT_OUT_W-1:0]    root
);

  logic [sdcs_pkg::RT_REM_W-1:0] rem_r [sdcs_pkg::RT_LAT-1];
  logic [sdcs_pkg::RT_IN_W-1:0]  x_r   [sdcs_pkg::RT_LAT-1];
  logic [sdcs_pkg::RT_OUT_W-1:0] res_r [sdcs_pkg::RT_LAT];

  for (genvar k = 0; k < sdcs_pkg::RT_LAT; k++) begin : g_stage
    logic [sdcs_pkg::RT_REM_W-1:0] rem_p;
    logic [sdcs_pkg::RT_OUT_W-1:0] res_p;
    logic [sdcs_pkg::RT_IN_W-1:0]  x_p;
    logic [sdcs_pkg::RT_REM_W:0]   rem_in;
    logic [sdcs_pkg::RT_REM_W:0]   trial;
    logic                          take;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign res_p = '0;
      assign x_p   = rad;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign res_p = res_r[k-1];
      assign x_p   = x_r[k-1];
    end

    // bring down the next two radicand bits, try (4*res+1)
    assign rem_in = {rem_p[sdcs_pkg::RT_REM_W-3:0], x_p[sdcs_pkg::RT_IN_W-1 -: 2]};
    assign trial  = {1'b0, res_p, 2'b01};
    assign take   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= {res_p[sdcs_pkg::RT_OUT_W-2:0], take};
      end
    end

    if (k < sdcs_pkg::RT_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? sdcs_pkg::RT_REM_W'(rem_in - trial)
                           : sdcs_pkg::RT_REM_W'(rem_in);
          x_r[k]   <= x_p << 2;
        end
      end
    end
  end

  assign root = res_r[sdcs_pkg::RT_LAT-1];

endmodule

// ===== rtl/core/sdcs_div.sv =====
// Pipelined unsigned restoring divider, saturating quotient on overflow.
module sdcs_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [sdcs_pkg::DV_N_W-1:0]      num,
  input  logic [sdcs_pkg::DV_D_W-1:0]      den,
  output logic [sdcs_pkg::DV_Q_W-1:0]      quo
);

  logic [sdcs_pkg::DV_D_W-1:0] rem_r [sdcs_pkg::DV_Q_W];
  logic [sdcs_pkg::DV_Q_W-1:0] lo_r  [sdcs_pkg::DV_Q_W];
  logic [sdcs_pkg::DV_D_W-1:0] den_r [sdcs_pkg::DV_Q_W];
  logic [sdcs_pkg::DV_Q_W-1:0] q_r   [1:sdcs_pkg::DV_Q_W];
  logic                        ovf_r [sdcs_pkg::DV_Q_W+1];

  // setup: upper dividend bits at or above the divisor mean the quotient won't fit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= sdcs_pkg::DV_D_W'(num[sdcs_pkg::DV_N_W-1:sdcs_pkg::DV_Q_W]);
      lo_r[0]  <= num[sdcs_pkg::DV_Q_W-1:0];
      den_r[0] <= den;
      ovf_r[0] <= (sdcs_pkg::DV_D_W'(num[sdcs_pkg::DV_N_W-1:sdcs_pkg::DV_Q_W]) >= den);
    end
  end

  for (genvar s = 1; s <= sdcs_pkg::DV_Q_W; s++) begin : g_stage
    logic [sdcs_pkg::DV_D_W:0]   rem_in;
    logic                        take;
    logic [sdcs_pkg::DV_Q_W-1:0] q_p;

    if (s == 1) begin : g_first
      assign q_p = '0;
    end else begin : g_next
      assign q_p = q_r[s-1];
    end

    assign rem_in = {rem_r[s-1], lo_r[s-1][sdcs_pkg::DV_Q_W-1]};
    assign take   = (rem_in >= {1'b0, den_r[s-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= {q_p[sdcs_pkg::DV_Q_W-2:0], take};
        ovf_r[s] <= ovf_r[s-1];
      end
    end

    if (s < sdcs_pkg::DV_Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? sdcs_pkg::DV_D_W'(rem_in - {1'b0, den_r[s-1]})
                           : sdcs_pkg::DV_D_W'(rem_in);
          lo_r[s]  <= lo_r[s-1] << 1;
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign quo = ovf_r[sdcs_pkg::DV_Q_W] ? {sdcs_pkg::DV_Q_W{1'b1}} : q_r[sdcs_pkg::DV_Q_W];

endmodule

// ===== rtl/core/signed_distance_to_cone_segment.sv =====
// Signed distance from a point to a round cone (two spheres and the cone hull between them).
// One point is taken every cycle while the pipe advances, and its result passes through the
// chain of three square-root units (32 stages each, one root bit per stage) and three
// restoring dividers (34 stages each, one quotient bit per stage) that the math needs in
// sequence: axis length, axial projection, distance from the axis, tangent
// offset, then the final root and the radius along the axis. The whole pipe advances as one
// while the output register is free or being taken, so a held result stalls every stage and
// nothing is lost or repeated. Registers are written at any time through the config channel,
// which is always ready, but must stay steady while items are in flight. A shape where one
// sphere holds the other or the centres coincide returns distance 0 with valid_res low.
module signed_distance_to_cone_segment (
  input  logic         clk,
  input  logic         rst_n,
  sdcs_in_if.sink      in_ch,
  sdcs_out_if.source   out_ch,
  sdcs_cfg_if.sink     cfg_ch
);

  // Per-item context, carried along every stage and delay line.
  typedef struct packed {
    logic signed [sdcs_pkg::DOT_W-1:0]    uv;
    logic [sdcs_pkg::SQ_W-1:0]            vv;
    logic [sdcs_pkg::SQ_W-1:0]            ww;
    logic [sdcs_pkg::SQ_W-1:0]            h2;
    logic [sdcs_pkg::RQ_W-1:0]            r1;
    logic [sdcs_pkg::RQ_W-1:0]            r2;
    logic signed [sdcs_pkg::DR_W-1:0]     dr;
    logic                                 deg;
    logic [sdcs_pkg::DV_D_W-1:0]          len;
    logic [sdcs_pkg::DV_D_W-1:0]          om;
    logic signed [sdcs_pkg::CRD_W-1:0]    ax;
    logic [sdcs_pkg::RT_OUT_W-1:0]        rvv;
    logic [sdcs_pkg::RT_OUT_W-1:0]        rww;
    logic                                 start_case;
    logic                                 end_case;
  } ctx_t;

  localparam int PW = sdcs_pkg::DV_D_W + sdcs_pkg::RQ_W;  // width of the two products fed to dividers

  // ---------------- configuration registers ----------------
  logic signed [sdcs_pkg::CRD_W-1:0] start_x_r, start_y_r, start_z_r;
  logic signed [sdcs_pkg::CRD_W-1:0] end_x_r, end_y_r, end_z_r;
  logic [sdcs_pkg::RAD_W-1:0]        start_rad_r, end_rad_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_z_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      end_z_r     <= '0;
      start_rad_r <= '0;
      end_rad_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (sdcs_pkg::cfg_reg_t'(cfg_ch.index))
        sdcs_pkg::REG_START_X:   start_x_r   <= cfg_ch.data;
        sdcs_pkg::REG_START_Y:   start_y_r   <= cfg_ch.data;
        sdcs_pkg::REG_START_Z:   start_z_r   <= cfg_ch.data;
        sdcs_pkg::REG_END_X:     end_x_r     <= cfg_ch.data;
        sdcs_pkg::REG_END_Y:     end_y_r     <= cfg_ch.data;
        sdcs_pkg::REG_END_Z:     end_z_r     <= cfg_ch.data;
        sdcs_pkg::REG_START_RAD: start_rad_r <= cfg_ch.data[sdcs_pkg::RAD_W-1:0];
        sdcs_pkg::REG_END_RAD:   end_rad_r   <= cfg_ch.data[sdcs_pkg::RAD_W-1:0];
      endcase
    end
  end

  // ---------------- pipeline advance and valid line ----------------
  logic                          adv;
  logic                          out_valid_r;
  logic [sdcs_pkg::PIPE_LAT-1:0] vld_r;

  // advance everything while the output slot is empty or being drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[sdcs_pkg::PIPE_LAT-2:0], in_ch.valid && in_ch.ready};
    end
  end

  // ---------------- stage 1: Q.13 differences ----------------
  logic signed [sdcs_pkg::CRD_W-1:0] pt [3];
  logic signed [sdcs_pkg::CRD_W-1:0] ca [3];
  logic signed [sdcs_pkg::CRD_W-1:0] cb [3];
  logic signed [sdcs_pkg::FX_W-1:0]  u_nxt [3], v_nxt [3], w_nxt [3];
  logic signed [sdcs_pkg::FX_W-1:0]  u_r [3], v_r [3], w_r [3];
  ctx_t                              c1_nxt, c1_r;

  always_comb begin
    pt[0] = in_ch.point_x;
    pt[1] = in_ch.point_y;
    pt[2] = in_ch.point_z;
    ca[0] = start_x_r;
    ca[1] = start_y_r;
    ca[2] = start_z_r;
    cb[0] = end_x_r;
    cb[1] = end_y_r;
    cb[2] = end_z_r;
    for (int i = 0; i < 3; i++) begin
      if (i < sdcs_pkg::DIM) begin
        u_nxt[i] = sdcs_pkg::fdiff(cb[i], ca[i]);
        v_nxt[i] = sdcs_pkg::fdiff(pt[i], ca[i]);
        w_nxt[i] = sdcs_pkg::fdiff(pt[i], cb[i]);
      end else begin
        u_nxt[i] = '0;
        v_nxt[i] = '0;
        w_nxt[i] = '0;
      end
    end
    c1_nxt    = '0;
    c1_nxt.r1 = start_rad_r[sdcs_pkg::RAD_W-1:3];
    c1_nxt.r2 = end_rad_r[sdcs_pkg::RAD_W-1:3];
    c1_nxt.dr = $signed({1'b0, c1_nxt.r1}) - $signed({1'b0, c1_nxt.r2});
  end

  // ---------------- stage 2: squares and dot products ----------------
  logic signed [sdcs_pkg::SQ_W-1:0]   uu_nxt [3], uv_nxt [3], vv_nxt [3], ww_nxt [3];
  logic signed [sdcs_pkg::SQ_W-1:0]   uu_r [3], uv_r [3], vv_r [3], ww_r [3];
  logic signed [2*sdcs_pkg::DR_W-1:0] dr2_nxt, dr2_r;
  ctx_t                               c2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu_nxt[i] = u_r[i] * u_r[i];
      uv_nxt[i] = u_r[i] * v_r[i];
      vv_nxt[i] = v_r[i] * v_r[i];
      ww_nxt[i] = w_r[i] * w_r[i];
    end
    dr2_nxt = c1_r.dr * c1_r.dr;
  end

  // ---------------- stage 3: sums, degenerate check ----------------
  logic signed [sdcs_pkg::SQ_W+1:0] uu_t, uv_t, vv_t, ww_t, om2_t;
  logic [sdcs_pkg::SQ_W-1:0]        uu3_nxt, om23_nxt, uu3_r, om23_r;
  ctx_t                             c3_nxt, c3_r;

  always_comb begin
    uu_t  = uu_r[0] + uu_r[1] + uu_r[2];
    uv_t  = uv_r[0] + uv_r[1] + uv_r[2];
    vv_t  = vv_r[0] + vv_r[1] + vv_r[2];
    ww_t  = ww_r[0] + ww_r[1] + ww_r[2];
    om2_t = uu_t - dr2_r;
    c3_nxt     = c2_r;
    c3_nxt.uv  = uv_t[sdcs_pkg::DOT_W-1:0];
    c3_nxt.vv  = vv_t[sdcs_pkg::SQ_W-1:0];
    c3_nxt.ww  = ww_t[sdcs_pkg::SQ_W-1:0];
    c3_nxt.deg = (om2_t <= 0);
    uu3_nxt    = uu_t[sdcs_pkg::SQ_W-1:0];
    om23_nxt   = c3_nxt.deg ? '0 : om2_t[sdcs_pkg::SQ_W-1:0];
  end

  // ---------------- roots: axis length and cone slant ----------------
  logic [sdcs_pkg::RT_OUT_W-1:0] len_q, om_q;
  ctx_t                          ca_r [sdcs_pkg::RT_LAT];
  ctx_t                          cb_nxt;
  ctx_t                          cb_r [sdcs_pkg::DV_LAT];
  logic [sdcs_pkg::DV_N_W-1:0]   uv_mag;
  logic [sdcs_pkg::DV_Q_W-1:0]   q1;

  sdcs_root u_root_len (
    .clk  (clk),
    .en   (adv),
    .rad  (sdcs_pkg::RT_IN_W'(uu3_r)),
    .root (len_q)
  );

  sdcs_root u_root_om (
    .clk  (clk),
    .en   (adv),
    .rad  (sdcs_pkg::RT_IN_W'(om23_r)),
    .root (om_q)
  );

  // ---------------- divide: axial projection ax = uv / len ----------------
  always_comb begin
    cb_nxt     = ca_r[sdcs_pkg::RT_LAT-1];
    cb_nxt.len = len_q[sdcs_pkg::DV_D_W-1:0];
    cb_nxt.om  = om_q[sdcs_pkg::DV_D_W-1:0];
    uv_mag     = cb_nxt.uv[sdcs_pkg::DOT_W-1] ? sdcs_pkg::DV_N_W'(-cb_nxt.uv)
                                              : sdcs_pkg::DV_N_W'(cb_nxt.uv);
  end

  sdcs_div u_div_ax (
    .clk (clk),
    .en  (adv),
    .num (uv_mag),
    .den (cb_nxt.len),
    .quo (q1)
  );

  // ---------------- stages 5 to 7: signed ax, ax^2, distance from axis ----------------
  ctx_t                              c5_nxt, c5_r, c6_r, c7_nxt, c7_r;
  logic signed [2*sdcs_pkg::CRD_W-1:0] axsq_nxt, axsq_r;
  logic signed [2*sdcs_pkg::CRD_W:0]   h2_t;

  always_comb begin
    c5_nxt    = cb_r[sdcs_pkg::DV_LAT-1];
    c5_nxt.ax = c5_nxt.uv[sdcs_pkg::DOT_W-1] ? -$signed(q1[sdcs_pkg::CRD_W-1:0])
                                             :  $signed(q1[sdcs_pkg::CRD_W-1:0]);
    axsq_nxt  = c5_r.ax * c5_r.ax;
    // clamp the axis-distance square at zero
    h2_t      = $signed({{(2*sdcs_pkg::CRD_W+1-sdcs_pkg::SQ_W){1'b0}}, c6_r.vv}) - axsq_r;
    c7_nxt    = c6_r;
    c7_nxt.h2 = (h2_t < 0) ? '0 : h2_t[sdcs_pkg::SQ_W-1:0];
  end

  // ---------------- roots: h, |v|, |w| ----------------
  logic [sdcs_pkg::RT_OUT_W-1:0] h_q, rvv_q, rww_q;
  ctx_t                          cc_r [sdcs_pkg::RT_LAT];
  ctx_t                          c8_nxt, c8_r;
  logic [PW-1:0]                 hdr_nxt, hdr_r;

  sdcs_root u_root_h (
    .clk  (clk),
    .en   (adv),
    .rad  (sdcs_pkg::RT_IN_W'(c7_r.h2)),
    .root (h_q)
  );

  sdcs_root u_root_vv (
    .clk  (clk),
    .en   (adv),
    .rad  (sdcs_pkg::RT_IN_W'(c7_r.vv)),
    .root (rvv_q)
  );

  sdcs_root u_root_ww (
    .clk  (clk),
    .en   (adv),
    .rad  (sdcs_pkg::RT_IN_W'(c7_r.ww)),
    .root (rww_q)
  );

  // ---------------- stage 8: h * |dr| ----------------
  always_comb begin
    c8_nxt     = cc_r[sdcs_pkg::RT_LAT-1];
    c8_nxt.rvv = rvv_q;
    c8_nxt.rww = rww_q;
    hdr_nxt    = h_q[sdcs_pkg::DV_D_W-1:0] * sdcs_pkg::dr_mag(c8_nxt.dr);
  end

  // ---------------- divide: tangent offset |delta| = h * |dr| / om ----------------
  logic [sdcs_pkg::DV_Q_W-1:0] q2;
  ctx_t                        cd_r [sdcs_pkg::DV_LAT];

  sdcs_div u_div_delta (
    .clk (clk),
    .en  (adv),
    .num (sdcs_pkg::DV_N_W'(hdr_r)),
    .den (c8_r.om),
    .quo (q2)
  );

  // ---------------- stages 9 to 11: normal foot and case select ----------------
  logic signed [sdcs_pkg::DV_Q_W+1:0] delta_t, sax_t;
  logic signed [sdcs_pkg::DV_Q_W+1:0] sax9_r;
  logic [sdcs_pkg::DV_Q_W-1:0]        ad9_r;
  ctx_t                               c9_nxt, c9_r, c10_r, c11_r;
  logic [2*sdcs_pkg::CRD_W-1:0]       ad2_nxt, ad2_r;
  logic [PW-1:0]                      drsax_nxt, drsax10_r, drsax11_r;
  logic [sdcs_pkg::RT_IN_W-1:0]       arg_nxt, arg_r;

  always_comb begin
    c9_nxt  = cd_r[sdcs_pkg::DV_LAT-1];
    delta_t = c9_nxt.dr[sdcs_pkg::DR_W-1] ? -$signed({2'b00, q2}) : $signed({2'b00, q2});
    sax_t   = c9_nxt.ax - delta_t;
    // foot at the start centre uses the start sphere, at the end centre the end sphere
    c9_nxt.start_case = (sax_t <= 0);
    c9_nxt.end_case   = (sax_t >= $signed({{(sdcs_pkg::DV_Q_W+2-sdcs_pkg::DV_D_W){1'b0}},
                                           c9_nxt.len}));
    ad2_nxt   = ad9_r[sdcs_pkg::CRD_W-1:0] * ad9_r[sdcs_pkg::CRD_W-1:0];
    drsax_nxt = sdcs_pkg::dr_mag(c9_r.dr) * sax9_r[sdcs_pkg::DV_D_W-1:0];
    arg_nxt   = sdcs_pkg::RT_IN_W'(c10_r.h2) + ad2_r;
  end

  // ---------------- root and divide: cone side ----------------
  logic [sdcs_pkg::RT_OUT_W-1:0] rc_q;
  logic [sdcs_pkg::RT_OUT_W-1:0] rc_d_r [2];
  logic [sdcs_pkg::DV_Q_W-1:0]   q3;
  ctx_t                          ce_r [sdcs_pkg::DV_LAT];

  sdcs_root u_root_cone (
    .clk  (clk),
    .en   (adv),
    .rad  (arg_r),
    .root (rc_q)
  );

  sdcs_div u_div_rad (
    .clk (clk),
    .en  (adv),
    .num (sdcs_pkg::DV_N_W'(drsax11_r)),
    .den (c11_r.len),
    .quo (q3)
  );

  // ---------------- final: pick case, scale, saturate ----------------
  ctx_t                                cf;
  logic signed [sdcs_pkg::RT_OUT_W+2:0] rad_t, d_t;
  logic signed [sdcs_pkg::RT_OUT_W+5:0] d8_t;
  logic signed [sdcs_pkg::CRD_W-1:0]    dist_nxt, dist_r;
  logic                                 vres_r;

  always_comb begin
    cf    = ce_r[sdcs_pkg::DV_LAT-1];
    rad_t = $signed({1'b0, cf.r1}) - (cf.dr[sdcs_pkg::DR_W-1] ? -$signed({1'b0, q3})
                                                             :  $signed({1'b0, q3}));
    priority if (cf.start_case) begin
      d_t = $signed({1'b0, cf.rvv}) - $signed({1'b0, cf.r1});
    end else if (cf.end_case) begin
      d_t = $signed({1'b0, cf.rww}) - $signed({1'b0, cf.r2});
    end else begin
      d_t = $signed({1'b0, rc_d_r[1]}) - rad_t;
    end
    d8_t = $signed({d_t, 3'b000});
    priority if (cf.deg) begin
      dist_nxt = '0;
    end else if (d8_t > sdcs_pkg::DIST_MAX) begin
      dist_nxt = sdcs_pkg::DIST_MAX;
    end else if (d8_t < sdcs_pkg::DIST_MIN) begin
      dist_nxt = sdcs_pkg::DIST_MIN;
    end else begin
      dist_nxt = d8_t[sdcs_pkg::CRD_W-1:0];
    end
  end

  // ---------------- data registers: all advance together ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]  <= u_nxt[i];
        v_r[i]  <= v_nxt[i];
        w_r[i]  <= w_nxt[i];
        uu_r[i] <= uu_nxt[i];
        uv_r[i] <= uv_nxt[i];
        vv_r[i] <= vv_nxt[i];
        ww_r[i] <= ww_nxt[i];
      end
      c1_r    <= c1_nxt;
      dr2_r   <= dr2_nxt;
      c2_r    <= c1_r;
      c3_r    <= c3_nxt;
      uu3_r   <= uu3_nxt;
      om23_r  <= om23_nxt;

      ca_r[0] <= c3_r;
      for (int i = 1; i < sdcs_pkg::RT_LAT; i++) ca_r[i] <= ca_r[i-1];
      cb_r[0] <= cb_nxt;
      for (int i = 1; i < sdcs_pkg::DV_LAT; i++) cb_r[i] <= cb_r[i-1];

      c5_r    <= c5_nxt;
      c6_r    <= c5_r;
      axsq_r  <= axsq_nxt;
      c7_r    <= c7_nxt;

      cc_r[0] <= c7_r;
      for (int i = 1; i < sdcs_pkg::RT_LAT; i++) cc_r[i] <= cc_r[i-1];
      c8_r    <= c8_nxt;
      hdr_r   <= hdr_nxt;
      cd_r[0] <= c8_r;
      for (int i = 1; i < sdcs_pkg::DV_LAT; i++) cd_r[i] <= cd_r[i-1];

      c9_r      <= c9_nxt;
      sax9_r    <= sax_t;
      ad9_r     <= q2;
      c10_r     <= c9_r;
      ad2_r     <= ad2_nxt;
      drsax10_r <= drsax_nxt;
      c11_r     <= c10_r;
      arg_r     <= arg_nxt;
      drsax11_r <= drsax10_r;

      // root finishes ahead of the divider; hold it in rc_d_r[0] and rc_d_r[1] to line up
      rc_d_r[0] <= rc_q;
      rc_d_r[1] <= rc_d_r[0];
      ce_r[0]   <= c11_r;
      for (int i = 1; i < sdcs_pkg::DV_LAT; i++) ce_r[i] <= ce_r[i-1];

      dist_r <= dist_nxt;
      vres_r <= !cf.deg;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[sdcs_pkg::PIPE_LAT-1];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.valid_res = vres_r;

endmodule

// ===== rtl/core/sdcs_checker.sv =====
// Port-level assertions for the round-cone distance block, with its bind.
module sdcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [sdcs_pkg::CRD_W-1:0] distance,
  input logic                             valid_res
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(valid_res))
    else $error("result changed while stalled");

  // a degenerate shape reports zero distance
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> distance == '0)
    else $error("degenerate result with nonzero distance");

  // a stalled output freezes the pipe, so no new item may enter
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe is stalled");

  // reset empties the output slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind signed_distance_to_cone_segment sdcs_checker u_sdcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .distance  (out_ch.distance),
  .valid_res (out_ch.valid_res)
);

// ===== tb/sv/signed_distance_to_cone_segment_checker.sv =====
// Checker that predicts and compares round-cone distance results.
`timescale 1ns / 1ps
module signed_distance_to_cone_segment_checker
  import sdcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sdcs_in_if   in_ch,
  sdcs_out_if  out_ch,
  sdcs_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   invalid_count
);

  typedef struct packed {
    logic signed [CRD_W-1:0] distance;
    logic                    valid_res;
  } dist_result_t;

  logic signed [CRD_W-1:0] c_start [3];
  logic signed [CRD_W-1:0] c_end [3];
  logic [RAD_W-1:0]        rad_start, rad_end;
  dist_result_t            expected_dists [$];

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic dist_result_t cone_distance(logic signed [CRD_W-1:0] pt [3]);
    dist_result_t r;
    longint uu, uv, vv, ww, u, v, w, r1, r2, dr, om2, len, om, ax, h2, h, delta, sax, d;
    longint unsigned ad;
    uu = 0; uv = 0; vv = 0; ww = 0;
    for (int i = 0; i < DIM; i++) begin
      u = (longint'(c_end[i]) - longint'(c_start[i])) >>> 3;
      v = (longint'(pt[i]) - longint'(c_start[i])) >>> 3;
      w = (longint'(pt[i]) - longint'(c_end[i])) >>> 3;
      uu += u * u;
      uv += u * v;
      vv += v * v;
      ww += w * w;
    end
    r1  = longint'(rad_start) >>> 3;
    r2  = longint'(rad_end) >>> 3;
    dr  = r1 - r2;
    om2 = uu - dr * dr;
    if (om2 <= 0) begin
      r.distance  = '0;
      r.valid_res = 1'b0;
      return r;
    end
    len = longint'(int_root(uu));
    om  = longint'(int_root(om2));
    ax  = uv / len;
    h2  = vv - ax * ax;
    if (h2 < 0) h2 = 0;
    h     = longint'(int_root(h2));
    delta = h * dr / om;
    sax   = ax - delta;
    // pick start sphere, end sphere or cone side by the normal foot
    if (sax <= 0) begin
      d = longint'(int_root(vv)) - r1;
    end else if (sax >= len) begin
      d = longint'(int_root(ww)) - r2;
    end else begin
      ad = (delta < 0) ? longint'(-delta) : delta;
      d  = longint'(int_root(longint'(h2) + ad * ad)) - (r1 - dr * sax / len);
    end
    d = d * 8;
    if (d > longint'(DIST_MAX)) d = DIST_MAX;
    if (d < longint'(DIST_MIN)) d = DIST_MIN;
    r.distance  = d[CRD_W-1:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  assign pending_count = expected_dists.size();

  always @(posedge clk) begin
    logic signed [CRD_W-1:0] pt [3];
    dist_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        c_start[i] = '0;
        c_end[i]   = '0;
      end
      rad_start = '0;
      rad_end   = '0;
      fail_count    <= 0;
      checked_count <= 0;
      invalid_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pt[0] = in_ch.point_x;
        pt[1] = in_ch.point_y;
        pt[2] = in_ch.point_z;
        expected_dists.push_back(cone_distance(pt));
      end
      if (out_ch.valid && out_ch.ready) begin
        checked_count <= checked_count + 1;
        if (!out_ch.valid_res) invalid_count <= invalid_count + 1;
        if (expected_dists.size() == 0) begin
          $display("%0t: unexpected result distance=%0d valid_res=%0b", $time,
                   out_ch.distance, out_ch.valid_res);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_dists.pop_front();
          if (exp_r.distance !== out_ch.distance || exp_r.valid_res !== out_ch.valid_res) begin
            $display("%0t: mismatch expected distance=%0d valid_res=%0b actual distance=%0d valid_res=%0b",
                     $time, exp_r.distance, exp_r.valid_res, out_ch.distance,
                     out_ch.valid_res);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_START_X:   c_start[0] = cfg_ch.data;
          REG_START_Y:   c_start[1] = cfg_ch.data;
          REG_START_Z:   c_start[2] = cfg_ch.data;
          REG_END_X:     c_end[0]   = cfg_ch.data;
          REG_END_Y:     c_end[1]   = cfg_ch.data;
          REG_END_Z:     c_end[2]   = cfg_ch.data;
          REG_START_RAD: rad_start  = cfg_ch.data[RAD_W-1:0];
          REG_END_RAD:   rad_end    = cfg_ch.data[RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/signed_distance_to_cone_segment_test.sv =====
// Top of the round-cone distance testbench: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps
module signed_distance_to_cone_segment_test;
  import sdcs_pkg::*;

  localparam int ONE        = 65536;   // 1.0 in Q16.16
  localparam int IDLE_LIMIT = 5000;    // cycles with no handshake before giving up
  localparam int SETTLE     = 200;     // a little more than the pipe latency

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, pending_count, checked_count, invalid_count;
  int   stall_pct;
  int   idle_cycles;
  int   points_sent;
  int   shapes_used;

  sdcs_in_if  in_ch ();
  sdcs_out_if out_ch ();
  sdcs_cfg_if cfg_ch ();

  always #6 clk = ~clk;

  signed_distance_to_cone_segment dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  signed_distance_to_cone_segment_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .invalid_count (invalid_count)
  );

  // Stall the result side on a random pattern; stall_pct 0 gives a free-running sink.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Write one register and wait for it to be taken; leave valid high for back-to-back writes.
  task automatic write_reg(cfg_reg_t idx, logic [CRD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_shape(int sx, int sy, int sz, int ex, int ey, int ez,
                           logic [CRD_W-1:0] rs, logic [CRD_W-1:0] re);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_END_Z, ez);
    write_reg(REG_START_RAD, rs);
    write_reg(REG_END_RAD, re);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    shapes_used++;
  endtask

  // Hold one point on the channel until taken; valid stays high for the next one.
  task automatic send_point(int px, int py, int pz);
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  // Drain every expected result, then let the pipe settle before touching registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int near_coord(int centre, int span);
    return centre + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random points in bursts: mostly near the shape, some anywhere in the full range.
  task automatic random_points(int count, int cx, int cy, int cz, int span);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 9) < 7)
          send_point(near_coord(cx, span), near_coord(cy, span), near_coord(cz, span));
        else
          send_point($urandom, $urandom, $urandom);
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) end_burst();
    end
  endtask

  initial begin
    int sx, sy, sz, ex, ey, ez, span;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_START_X;
    cfg_ch.data   <= '0;
    stall_pct      = 0;
    idle_cycles    = 0;
    points_sent    = 0;
    shapes_used    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers describe coincident centres: every result is degenerate.
    for (int i = 0; i < 6; i++) send_point($urandom, $urandom, $urandom);
    drain();

    // Tapered cone along x: both spheres, cone side, foot on the axis, extremes.
    stall_pct = 30;
    set_shape(0, 0, 0, 10 * ONE, 0, 0, 2 * ONE, 1 * ONE);
    send_point(0, 0, 0);
    send_point(10 * ONE, 0, 0);
    send_point(5 * ONE, 0, 0);
    send_point(-5 * ONE, 0, 0);
    send_point(15 * ONE, 0, 0);
    send_point(5 * ONE, 3 * ONE, 0);
    send_point(5 * ONE, 0, -4 * ONE);
    end_burst();
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);
    drain();

    // Cylinder: the foot lands exactly on each centre at the ends.
    stall_pct = 0;
    set_shape(0, 0, 0, 0, 8 * ONE, 0, 3 * ONE, 3 * ONE);
    send_point(2 * ONE, 0, 0);
    send_point(0, 8 * ONE, 2 * ONE);
    send_point(0, 4 * ONE, 0);
    send_point(-ONE, -ONE, -ONE);
    send_point(0, 12 * ONE, 0);
    drain();

    // Widest axis and largest start radius: saturation territory.
    stall_pct = 50;
    set_shape(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    random_points(90, 0, 0, 0, 32'h7fff_0000);
    drain();

    // One sphere swallows the other: degenerate shape.
    stall_pct = 10;
    set_shape(ONE, ONE, ONE, ONE + ONE / 2, ONE, ONE, 5 * ONE, 3 * ONE);
    random_points(40, ONE, ONE, ONE, 8 * ONE);
    drain();

    // Random cones, small end first or last, with unused radius bits set at random.
    for (int ph = 0; ph < 8; ph++) begin
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
      sx = near_coord(0, 200 * ONE);
      sy = near_coord(0, 200 * ONE);
      sz = near_coord(0, 200 * ONE);
      ex = near_coord(sx, 100 * ONE);
      ey = near_coord(sy, 100 * ONE);
      ez = near_coord(sz, 100 * ONE);
      span = 150 * ONE;
      set_shape(sx, sy, sz, ex, ey, ez,
                {$urandom_range(0, 1), 31'($urandom_range(0, 40 * ONE))},
                {$urandom_range(0, 1), 31'($urandom_range(0, 40 * ONE))});
      random_points(115, sx / 2 + ex / 2, sy / 2 + ey / 2, sz / 2 + ez / 2, span);
      drain();
    end

    $display("Sent %0d points over %0d register settings; checked %0d results, %0d degenerate",
             points_sent, shapes_used, checked_count, invalid_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
